@@ hw/rtl/c_like_token_scanner_macros.svh @@
// assertion helpers shared by the scanner modules
`ifndef C_LIKE_TOKEN_SCANNER_MACROS_SVH
`define C_LIKE_TOKEN_SCANNER_MACROS_SVH

`ifndef SYNTH
`define CTKS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define CTKS_ASSERT_NEXT(lbl, clk, rst_n, cond, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) else $error(msg);
`else
`define CTKS_ASSERT(lbl, clk, rst_n, prop, msg)
`define CTKS_ASSERT_NEXT(lbl, clk, rst_n, cond, expr, msg)
`endif

`endif

@@ hw/rtl/ctks_pkg.sv @@
package ctks_pkg;

	localparam int OFFSET_BITS_DEF = 24;
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int POS_W = 24;

	typedef logic [3:0] kind_t;

	localparam kind_t K_END     = 4'd0;
	localparam kind_t K_UNKNOWN = 4'd1;
	localparam kind_t K_IDENT   = 4'd2;
	localparam kind_t K_LPAREN  = 4'd3;
	localparam kind_t K_RPAREN  = 4'd4;
	localparam kind_t K_LBRACE  = 4'd5;
	localparam kind_t K_RBRACE  = 4'd6;
	localparam kind_t K_LBRACK  = 4'd7;
	localparam kind_t K_RBRACK  = 4'd8;
	localparam kind_t K_COLON   = 4'd9;
	localparam kind_t K_STRING  = 4'd10;
	localparam kind_t K_STAR    = 4'd11;
	localparam kind_t K_SEMI    = 4'd12;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_SLASH  = 8'h2f;
	localparam logic [7:0] CH_STAR   = 8'h2a;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_UNDER  = 8'h5f;
	localparam logic [7:0] CH_LF     = 8'h0a;
	localparam logic [7:0] CH_CR     = 8'h0d;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} in_t;

	typedef struct packed {
		kind_t            token_kind;
		logic [POS_W-1:0] start_pos;
		logic [POS_W-1:0] end_pos;
		logic             last_of_run;
	} out_t;

	// tokens caused by one byte
	typedef struct packed {
		out_t first;
		out_t second;
		logic two;
	} grp_t;

	function automatic logic is_letter(input logic [7:0] c);
		return c inside {[8'h61:8'h7a], [8'h41:8'h5a]};
	endfunction

	function automatic logic is_tail(input logic [7:0] c);
		return is_letter(c) || (c inside {[8'h30:8'h39]}) || (c == CH_UNDER);
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c inside {[8'h09:8'h0d], 8'h20};
	endfunction

	function automatic kind_t punct_kind(input logic [7:0] c);
		kind_t k;
		case (c)
			8'h28: k = K_LPAREN;
			8'h29: k = K_RPAREN;
			8'h7b: k = K_LBRACE;
			8'h7d: k = K_RBRACE;
			8'h5b: k = K_LBRACK;
			8'h5d: k = K_RBRACK;
			8'h3a: k = K_COLON;
			8'h2a: k = K_STAR;
			8'h3b: k = K_SEMI;
			default: k = K_UNKNOWN;
		endcase
		return k;
	endfunction

endpackage

@@ hw/rtl/ctks_front.sv @@
module ctks_front #(
	parameter int OFFSET_BITS = ctks_pkg::OFFSET_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ctks_pkg::in_t     item,
	input  logic              full,
	output logic              wr,
	output ctks_pkg::grp_t    grp
);

	localparam int OB = OFFSET_BITS;
	localparam int PW = ctks_pkg::POS_W;

	localparam logic [2:0] M_IDLE   = 3'd0;
	localparam logic [2:0] M_SLASH  = 3'd1;
	localparam logic [2:0] M_LINE   = 3'd2;
	localparam logic [2:0] M_BLOCK  = 3'd3;
	localparam logic [2:0] M_BSTAR  = 3'd4;
	localparam logic [2:0] M_IDENT  = 3'd5;
	localparam logic [2:0] M_STRING = 3'd6;
	localparam logic [2:0] M_ESC    = 3'd7;

	logic [2:0]    mode_q, mode_n;
	logic [OB-1:0] pos_q, pos_n;
	logic [OB-1:0] pstart_q, pstart_n;

	logic [7:0]    c;
	logic          acc, is_end, run_idle;
	logic [OB-1:0] pinc, psinc;

	logic            pre_v, post_v;
	ctks_pkg::kind_t pre_k, post_k;
	logic [OB-1:0]   pre_s, pre_e, post_s, post_e;

	assign acc    = push && !full;
	assign c      = item.text_byte;
	assign is_end = item.end_of_text || (c == ctks_pkg::CH_NUL);
	assign pinc   = (pos_q == '1) ? pos_q : pos_q + 1'b1;
	assign psinc  = (pstart_q == '1) ? pstart_q : pstart_q + 1'b1;

	always_comb begin
		mode_n   = mode_q;
		pos_n    = pinc;
		pstart_n = pstart_q;
		run_idle = 1'b0;
		pre_v    = 1'b0;
		pre_k    = ctks_pkg::K_UNKNOWN;
		pre_s    = pstart_q;
		pre_e    = pos_q;
		post_v   = 1'b0;
		post_k   = ctks_pkg::K_END;
		post_s   = pos_q;
		post_e   = pos_q;
		if (is_end) begin
			case (mode_q)
				M_SLASH: begin
					pre_v = 1'b1;
					pre_e = psinc;
				end
				M_IDENT: begin
					pre_v = 1'b1;
					pre_k = ctks_pkg::K_IDENT;
				end
				M_STRING, M_ESC: begin
					pre_v = 1'b1;
					pre_k = ctks_pkg::K_STRING;
				end
				default: pre_v = 1'b0;
			endcase
			post_v   = 1'b1;
			mode_n   = M_IDLE;
			pos_n    = '0;
			pstart_n = '0;
		end else begin
			case (mode_q)
				M_SLASH: begin
					if (c == ctks_pkg::CH_SLASH) begin
						mode_n = M_LINE;
					end else if (c == ctks_pkg::CH_STAR) begin
						mode_n = M_BLOCK;
					end else begin
						pre_v    = 1'b1;
						pre_e    = psinc;
						run_idle = 1'b1;
					end
				end
				M_LINE: begin
					if (c == ctks_pkg::CH_LF || c == ctks_pkg::CH_CR)
						mode_n = M_IDLE;
				end
				M_BLOCK: begin
					if (c == ctks_pkg::CH_STAR)
						mode_n = M_BSTAR;
				end
				M_BSTAR: begin
					if (c == ctks_pkg::CH_SLASH)
						mode_n = M_IDLE;
					else if (c != ctks_pkg::CH_STAR)
						mode_n = M_BLOCK;
				end
				M_IDENT: begin
					if (!ctks_pkg::is_tail(c)) begin
						pre_v    = 1'b1;
						pre_k    = ctks_pkg::K_IDENT;
						run_idle = 1'b1;
					end
				end
				M_STRING: begin
					if (c == ctks_pkg::CH_QUOTE) begin
						pre_v  = 1'b1;
						pre_k  = ctks_pkg::K_STRING;
						mode_n = M_IDLE;
					end else if (c == ctks_pkg::CH_BSLASH) begin
						mode_n = M_ESC;
					end
				end
				M_ESC: mode_n = M_STRING;
				default: run_idle = 1'b1;
			endcase
			if (run_idle) begin
				mode_n = M_IDLE;
				if (ctks_pkg::is_space(c)) begin
					mode_n = M_IDLE;
				end else if (c == ctks_pkg::CH_SLASH) begin
					mode_n   = M_SLASH;
					pstart_n = pos_q;
				end else if (c == ctks_pkg::CH_QUOTE) begin
					mode_n   = M_STRING;
					pstart_n = pinc;
				end else if (ctks_pkg::is_letter(c)) begin
					mode_n   = M_IDENT;
					pstart_n = pos_q;
				end else begin
					post_v = 1'b1;
					post_k = ctks_pkg::punct_kind(c);
					post_e = pinc;
				end
			end
		end
	end

	always_comb begin
		grp = '0;
		if (pre_v) begin
			grp.first.token_kind   = pre_k;
			grp.first.start_pos    = PW'(pre_s);
			grp.first.end_pos      = PW'(pre_e);
			grp.first.last_of_run  = !post_v;
			grp.second.token_kind  = post_k;
			grp.second.start_pos   = PW'(post_s);
			grp.second.end_pos     = PW'(post_e);
			grp.second.last_of_run = 1'b1;
			grp.two                = post_v;
		end else begin
			grp.first.token_kind   = post_k;
			grp.first.start_pos    = PW'(post_s);
			grp.first.end_pos      = PW'(post_e);
			grp.first.last_of_run  = 1'b1;
		end
	end

	assign wr = acc && (pre_v || post_v);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_IDLE;
			pos_q    <= '0;
			pstart_q <= '0;
		end else if (acc) begin
			mode_q   <= mode_n;
			pos_q    <= pos_n;
			pstart_q <= pstart_n;
		end
	end

endmodule

@@ hw/rtl/ctks_fifo.sv @@
`include "c_like_token_scanner_macros.svh"

module ctks_fifo #(
	parameter int DEPTH = ctks_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  ctks_pkg::grp_t wdata,
	output logic           full,
	input  logic           rd,
	output ctks_pkg::grp_t rdata,
	output logic           empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	ctks_pkg::grp_t mem_q [DEPTH];
	logic [AW-1:0]  wptr_q, rptr_q;
	logic [CW-1:0]  cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr)
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			if (rd)
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			case ({wr, rd})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`CTKS_ASSERT(a_no_overfill, clk, arst_n, !(wr && full), "write into a full queue")
	`CTKS_ASSERT(a_no_underrun, clk, arst_n, !(rd && empty), "read from an empty queue")
	`CTKS_ASSERT_NEXT(a_cnt_down, clk, arst_n, rd && !wr, cnt_q == CW'($past(cnt_q) - 1'b1), "count lost on read")

endmodule

@@ hw/rtl/ctks_back.sv @@
`include "c_like_token_scanner_macros.svh"

module ctks_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           fifo_empty,
	input  ctks_pkg::grp_t fifo_data,
	output logic           fifo_rd,
	output logic           empty,
	input  logic           pop,
	output ctks_pkg::out_t token
);

	ctks_pkg::grp_t grp_q;
	logic           hold_q;
	logic           idx_q;
	logic           adv, cur_last;

	assign cur_last = !grp_q.two || idx_q;
	assign adv      = pop && hold_q;
	assign fifo_rd  = !fifo_empty && (!hold_q || (adv && cur_last));
	assign empty    = !hold_q;
	assign token    = idx_q ? grp_q.second : grp_q.first;

	always_ff @(posedge clk) begin
		if (fifo_rd)
			grp_q <= fifo_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 1'b0;
			idx_q  <= 1'b0;
		end else if (fifo_rd) begin
			hold_q <= 1'b1;
			idx_q  <= 1'b0;
		end else if (adv) begin
			if (cur_last) begin
				hold_q <= 1'b0;
				idx_q  <= 1'b0;
			end else begin
				idx_q <= 1'b1;
			end
		end
	end

	`CTKS_ASSERT(a_second_valid, clk, arst_n, !idx_q || (hold_q && grp_q.two), "second slot without pair")
	`CTKS_ASSERT_NEXT(a_pair_follows, clk, arst_n, adv && !cur_last, hold_q && idx_q, "second token dropped")

endmodule

@@ hw/rtl/c_like_token_scanner.sv @@
// c_like_token_scanner: streaming tokenizer for c-like source text
// input side is a queue write port: item carries one text byte or an end
// flag, taken on a rising edge with push high and full low
// result side is a queue read port: while empty is low, token holds the
// oldest token (kind, start, end, last_of_run); pop with empty low takes it
// a byte gives zero, one or two tokens; last_of_run marks the final one
// an end flag or nul byte flushes any open token, emits an end token and
// restarts offsets at zero for the next text
// a byte's first token is written into the group queue, then loaded into
// the output register before it shows on token and can be popped
// throughput: one byte per cycle while full is low; the output side drains
// one token per cycle, so bytes giving two tokens are absorbed by the group
// queue between the scanner and the output stage (QUEUE_DEPTH deep); when
// the receiver stalls the queue fills and full rises; nothing is lost
// reset clears the scanner mode, offsets and both queues
module c_like_token_scanner #(
	parameter int OFFSET_BITS = ctks_pkg::OFFSET_BITS_DEF,
	parameter int QUEUE_DEPTH = ctks_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ctks_pkg::in_t  item,
	output logic           full,
	input  logic           pop,
	output ctks_pkg::out_t token,
	output logic           empty
);

	logic           q_wr, q_rd, q_full, q_empty;
	ctks_pkg::grp_t q_wdata, q_rdata;

	assign full = q_full;

	ctks_front #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.item  (item),
		.full  (q_full),
		.wr    (q_wr),
		.grp   (q_wdata)
	);

	ctks_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (q_wr),
		.wdata (q_wdata),
		.full  (q_full),
		.rd    (q_rd),
		.rdata (q_rdata),
		.empty (q_empty)
	);

	ctks_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.fifo_empty(q_empty),
		.fifo_data (q_rdata),
		.fifo_rd   (q_rd),
		.empty     (empty),
		.pop       (pop),
		.token     (token)
	);

endmodule

@@ tb/sv/c_like_token_scanner_checker.sv @@
module c_like_token_scanner_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ctks_pkg::in_t  item,
	input  logic           full,
	input  logic           pop,
	input  ctks_pkg::out_t token,
	input  logic           empty,
	output int             fails,
	output int             waiting,
	output int             beats,
	output int             tokens
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int POS_W = ctks_pkg::POS_W;
	localparam logic [POS_W-1:0] AT_MAX = '1;

	typedef enum logic [2:0] {
		S_IDLE, S_SLASH, S_LINE, S_BLOCK, S_BSTAR, S_IDENT, S_STRING, S_ESC
	} scan_e;

	scan_e            mode;
	logic [POS_W-1:0] at;
	logic [POS_W-1:0] open_at;
	ctks_pkg::out_t   run[$];
	ctks_pkg::out_t   tokens_due[$];
	int               miss;
	int               beat_n;
	int               tok_n;

	function automatic logic [POS_W-1:0] bump(input logic [POS_W-1:0] p);
		return (p == AT_MAX) ? AT_MAX : p + 1'b1;
	endfunction

	function automatic bit letter(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit word_char(input logic [7:0] c);
		return letter(c) || (c >= "0" && c <= "9") || c == ctks_pkg::CH_UNDER;
	endfunction

	function automatic bit blank(input logic [7:0] c);
		return c == " " || (c >= 8'h09 && c <= ctks_pkg::CH_CR);
	endfunction

	function automatic ctks_pkg::kind_t single_kind(input logic [7:0] c);
		case (c)
			"(":               return ctks_pkg::K_LPAREN;
			")":               return ctks_pkg::K_RPAREN;
			"{":               return ctks_pkg::K_LBRACE;
			"}":               return ctks_pkg::K_RBRACE;
			"[":               return ctks_pkg::K_LBRACK;
			"]":               return ctks_pkg::K_RBRACK;
			":":               return ctks_pkg::K_COLON;
			ctks_pkg::CH_STAR: return ctks_pkg::K_STAR;
			";":               return ctks_pkg::K_SEMI;
			default:           return ctks_pkg::K_UNKNOWN;
		endcase
	endfunction

	function automatic void emit(input ctks_pkg::kind_t k, input logic [POS_W-1:0] s,
			input logic [POS_W-1:0] e);
		ctks_pkg::out_t t;
		t.token_kind  = k;
		t.start_pos   = s;
		t.end_pos     = e;
		t.last_of_run = 1'b0;
		if (run.size() < 2)
			run.push_back(t);
	endfunction

	// a byte arriving with no token open
	function automatic void take_fresh(input logic [7:0] c);
		mode = S_IDLE;
		if (blank(c))
			return;
		if (c == ctks_pkg::CH_SLASH) begin
			mode    = S_SLASH;
			open_at = at;
		end else if (c == ctks_pkg::CH_QUOTE) begin
			mode    = S_STRING;
			open_at = bump(at);
		end else if (letter(c)) begin
			mode    = S_IDENT;
			open_at = at;
		end else begin
			emit(single_kind(c), at, bump(at));
		end
	endfunction

	function automatic void absorb(input ctks_pkg::in_t it);
		logic [7:0] c;
		c = it.text_byte;
		run.delete();
		if (it.end_of_text || c == ctks_pkg::CH_NUL) begin
			case (mode)
				S_SLASH:         emit(ctks_pkg::K_UNKNOWN, open_at, bump(open_at));
				S_IDENT:         emit(ctks_pkg::K_IDENT, open_at, at);
				S_STRING, S_ESC: emit(ctks_pkg::K_STRING, open_at, at);
				default: ;
			endcase
			emit(ctks_pkg::K_END, at, at);
			mode    = S_IDLE;
			at      = '0;
			open_at = '0;
		end else begin
			case (mode)
				S_SLASH: begin
					if (c == ctks_pkg::CH_SLASH) begin
						mode = S_LINE;
					end else if (c == ctks_pkg::CH_STAR) begin
						mode = S_BLOCK;
					end else begin
						emit(ctks_pkg::K_UNKNOWN, open_at, bump(open_at));
						take_fresh(c);
					end
				end
				S_LINE: begin
					if (c == ctks_pkg::CH_LF || c == ctks_pkg::CH_CR)
						mode = S_IDLE;
				end
				S_BLOCK: begin
					if (c == ctks_pkg::CH_STAR)
						mode = S_BSTAR;
				end
				S_BSTAR: begin
					if (c == ctks_pkg::CH_SLASH)
						mode = S_IDLE;
					else if (c != ctks_pkg::CH_STAR)
						mode = S_BLOCK;
				end
				S_IDENT: begin
					if (!word_char(c)) begin
						emit(ctks_pkg::K_IDENT, open_at, at);
						take_fresh(c);
					end
				end
				S_STRING: begin
					if (c == ctks_pkg::CH_QUOTE) begin
						emit(ctks_pkg::K_STRING, open_at, at);
						mode = S_IDLE;
					end else if (c == ctks_pkg::CH_BSLASH) begin
						mode = S_ESC;
					end
				end
				S_ESC: mode = S_STRING;
				default: take_fresh(c);
			endcase
			at = bump(at);
		end
		if (run.size() != 0)
			run[run.size()-1].last_of_run = 1'b1;
		foreach (run[i])
			tokens_due.push_back(run[i]);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		ctks_pkg::out_t want;
		if (!arst_n) begin
			mode    = S_IDLE;
			at      = '0;
			open_at = '0;
			tokens_due.delete();
			miss    = 0;
			beat_n  = 0;
			tok_n   = 0;
		end else begin
			if (pop && !empty) begin
				tok_n++;
				if (tokens_due.size() == 0) begin
					if (miss < 10)
						$display("unexpected token: kind %0d start %0d end %0d last %0b",
							token.token_kind, token.start_pos, token.end_pos,
							token.last_of_run);
					miss++;
				end else begin
					want = tokens_due.pop_front();
					if (token.token_kind !== want.token_kind
							|| token.start_pos !== want.start_pos
							|| token.end_pos !== want.end_pos
							|| token.last_of_run !== want.last_of_run) begin
						if (miss < 10)
							$display({"token %0d mismatch: expected kind %0d start %0d end %0d",
								" last %0b, got kind %0d start %0d end %0d last %0b"},
								tok_n, want.token_kind, want.start_pos, want.end_pos,
								want.last_of_run, token.token_kind, token.start_pos,
								token.end_pos, token.last_of_run);
						miss++;
					end
				end
			end
			if (push && !full) begin
				beat_n++;
				absorb(item);
			end
		end
		fails   <= miss;
		waiting <= tokens_due.size();
		beats   <= beat_n;
		tokens  <= tok_n;
	end

endmodule

@@ tb/sv/tb_c_like_token_scanner.sv @@
module tb_c_like_token_scanner;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEM_TARGET = 1350;
	localparam int STALL_LIMIT = 400;
	localparam int SETTLE      = 16;

	logic           clk    = 1'b0;
	logic           arst_n = 1'b0;
	logic           push   = 1'b0;
	ctks_pkg::in_t  item   = '0;
	logic           pop    = 1'b0;
	logic           full;
	logic           empty;
	ctks_pkg::out_t token;

	int fails;
	int waiting;
	int beats;
	int tokens;
	int sent  = 0;
	int texts = 0;
	int idle_run;
	bit calm  = 1'b0;

	c_like_token_scanner u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.item   (item),
		.full   (full),
		.pop    (pop),
		.token  (token),
		.empty  (empty)
	);

	c_like_token_scanner_checker u_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.item    (item),
		.full    (full),
		.pop     (pop),
		.token   (token),
		.empty   (empty),
		.fails   (fails),
		.waiting (waiting),
		.beats   (beats),
		.tokens  (tokens)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	task automatic send_beat(input logic [7:0] b, input logic flag);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		item <= '{text_byte: b, end_of_text: flag};
		do @(posedge clk); while (full);
		sent++;
	endtask

	task automatic send_text(input string s);
		foreach (s[i])
			send_beat(s[i], 1'b0);
	endtask

	// mostly well-formed tokens with random content, some noise, then an end
	task automatic random_text();
		int         pieces;
		bit         open_end;
		logic [7:0] b;
		logic [7:0] prev;
		string      punct;
		punct  = "(){}[]:*;";
		pieces = $urandom_range(1, 14);
		for (int p = 0; p < pieces; p++) begin
			open_end = (p == pieces - 1) && ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 10))
				0, 1: begin
					b = 8'($urandom_range(0, 1) ? $urandom_range("a", "z")
						: $urandom_range("A", "Z"));
					send_beat(b, 1'b0);
					repeat ($urandom_range(0, 6)) begin
						case ($urandom_range(0, 3))
							0: b = 8'($urandom_range("a", "z"));
							1: b = 8'($urandom_range("A", "Z"));
							2: b = 8'($urandom_range("0", "9"));
							default: b = ctks_pkg::CH_UNDER;
						endcase
						send_beat(b, 1'b0);
					end
				end
				2, 3: send_beat(punct[$urandom_range(0, 8)], 1'b0);
				4: send_beat(8'($urandom_range(0, 1) ? " "
					: $urandom_range(8'h09, ctks_pkg::CH_CR)), 1'b0);
				5: begin
					send_beat(ctks_pkg::CH_QUOTE, 1'b0);
					repeat ($urandom_range(0, 8)) begin
						if ($urandom_range(0, 5) == 0) begin
							send_beat(ctks_pkg::CH_BSLASH, 1'b0);
							send_beat(8'($urandom_range(1, 255)), 1'b0);
						end else begin
							do b = 8'($urandom_range(1, 255));
							while (b == ctks_pkg::CH_QUOTE || b == ctks_pkg::CH_BSLASH);
							send_beat(b, 1'b0);
						end
					end
					if (!open_end)
						send_beat(ctks_pkg::CH_QUOTE, 1'b0);
					else if ($urandom_range(0, 1))
						send_beat(ctks_pkg::CH_BSLASH, 1'b0);
				end
				6: begin
					send_beat(ctks_pkg::CH_SLASH, 1'b0);
					send_beat(ctks_pkg::CH_SLASH, 1'b0);
					repeat ($urandom_range(0, 10)) begin
						do b = 8'($urandom_range(1, 255));
						while (b == ctks_pkg::CH_LF || b == ctks_pkg::CH_CR);
						send_beat(b, 1'b0);
					end
					if (!open_end)
						send_beat($urandom_range(0, 1) ? ctks_pkg::CH_LF : ctks_pkg::CH_CR, 1'b0);
				end
				7: begin
					send_beat(ctks_pkg::CH_SLASH, 1'b0);
					send_beat(ctks_pkg::CH_STAR, 1'b0);
					prev = ctks_pkg::CH_STAR;
					repeat ($urandom_range(0, 10)) begin
						b = $urandom_range(0, 2) == 0 ? ctks_pkg::CH_STAR
							: 8'($urandom_range(1, 255));
						if (prev == ctks_pkg::CH_STAR && b == ctks_pkg::CH_SLASH)
							b = ctks_pkg::CH_STAR;
						send_beat(b, 1'b0);
						prev = b;
					end
					if (!open_end) begin
						send_beat(ctks_pkg::CH_STAR, 1'b0);
						send_beat(ctks_pkg::CH_SLASH, 1'b0);
					end
				end
				8: send_beat(ctks_pkg::CH_SLASH, 1'b0);
				9: send_beat(8'($urandom_range(1, 255)), 1'b0);
				default: send_beat(8'($urandom_range(0, 1) ? ctks_pkg::CH_UNDER
					: $urandom_range("0", "9")), 1'b0);
			endcase
		end
		if ($urandom_range(0, 1))
			send_beat(8'($urandom_range(0, 255)), 1'b1);
		else
			send_beat(ctks_pkg::CH_NUL, 1'b0);
	endtask

	// receiver with random stalls
	initial begin
		int stall;
		do @(posedge clk); while (!arst_n);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 4);
			if (stall != 0) begin
				pop <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
		end
	end

	initial begin
		idle_run = 0;
		while (idle_run < STALL_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty))
				idle_run = 0;
			else
				idle_run++;
		end
		$display("watchdog: no beat for %0d cycles, %0d tokens still due", STALL_LIMIT, waiting);
		$display("tb: failure");
		$finish;
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every punctuation kind, identifier tail characters, end flag ignoring its byte
		send_text("a_9(){}[]:*;");
		send_beat(ctks_pkg::CH_SLASH, 1'b1);
		// unterminated string with trailing backslash, flushed by nul
		send_text("\"x\\");
		send_beat(ctks_pkg::CH_NUL, 1'b0);
		// lone slash right before the end
		send_text("/");
		send_beat(8'hff, 1'b1);
		// unterminated block comment dropped
		send_text("/*");
		send_beat(ctks_pkg::CH_NUL, 1'b1);
		// high byte, underscore, digit, lone slash before an identifier
		send_beat(8'hff, 1'b0);
		send_text("_1/x");
		send_beat(ctks_pkg::CH_NUL, 1'b0);

		while (sent < ITEM_TARGET) begin
			calm = ($urandom_range(0, 4) == 0);
			random_text();
			texts++;
		end
		calm = 1'b0;
		push <= 1'b0;

		while (waiting != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("run covered %0d bytes: directed cases and %0d random texts", beats, texts);
		$display("%0d tokens compared, %0d mismatches", tokens, fails);
		if (fails == 0 && waiting == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
